@@ rtl/fmv_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the four-operator FM voice.
// No dependencies; every other file imports this package.
package fmv_pkg;

    // Channel payload widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SAMPLE_W   = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_OP2        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_OP3        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_OP4        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_LEVEL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULATOR_LEVELS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SELECTS     = 3'd6;

    // Operator slots: slot 0 is the carrier, slot 3 heads the chain
    localparam logic [1:0] OP1 = 2'd0;
    localparam logic [1:0] OP2 = 2'd1;
    localparam logic [1:0] OP3 = 2'd2;
    localparam logic [1:0] OP4 = 2'd3;

    // Phase increment divider: every increment is X * 2^P / (16 * rate)
    localparam int unsigned SAMPLE_RATE = 48000;
    localparam int unsigned DIVISOR     = 16 * SAMPLE_RATE;
    localparam int          X_W         = 24;

    // 16 * rate = DIV_ODD << DIV_POW; floor(n / DIV_ODD) = (n * RECIP) >> RECIP_SHIFT
    // is exact for every n below 2^32, so for any NUM_W-bit operand
    localparam int                 DIV_POW     = 11;
    localparam int unsigned        DIV_ODD     = DIVISOR >> DIV_POW;
    localparam int                 DIV_ODD_W   = 9;
    localparam int                 NUM_W       = 30;
    localparam int                 RECIP_W     = 31;
    localparam int                 RECIP_SHIFT = 39;
    localparam logic [RECIP_W-1:0] RECIP       = 31'd1466015504;

    // Waveform and index widths
    localparam int WAVE_W  = 16;
    localparam int IDX_W   = 8;
    localparam int FRAC_W  = 21;   // phase scaled to the 2^21 step of value*level
    localparam int PROD_W  = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_ADVANCE,
        S_MUL,
        S_LOOK,
        S_SCALE,
        S_OUT
    } t_fmv_state;

    typedef struct packed {
        logic       cfg_we;
        logic       div_start;
        logic       inc_store;
        logic       phase_adv;
        logic       mul_en;
        logic       mul_scale;
        logic       look_en;
        logic       out_load;
        logic [1:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_sts;

endpackage

@@ rtl/fmv_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the FM voice: tick requests, samples,
// configuration writes. Depends on fmv_pkg.
interface fmv_tick_if import fmv_pkg::*; ();
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

interface fmv_sample_if import fmv_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface fmv_cfg_if import fmv_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/fmv_wave_rom.sv @@
`timescale 1ns / 1ps
// Waveform ROM: six 256-entry Q1.14 shapes; the sine ones use a 65-entry quarter sine.
// Registered read. Depends on fmv_pkg.
module fmv_wave_rom import fmv_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [3:0]               i_sel,
    input  logic [IDX_W-1:0]         i_idx,
    output logic signed [WAVE_W-1:0] o_value
);

    localparam logic [3:0] WAVE_SINE   = 4'd0;
    localparam logic [3:0] WAVE_HALF   = 4'd1;
    localparam logic [3:0] WAVE_FAST   = 4'd2;
    localparam logic [3:0] WAVE_SQUARE = 4'd3;
    localparam logic [3:0] WAVE_TRI    = 4'd4;
    localparam logic [3:0] WAVE_SAW    = 4'd5;

    localparam logic signed [WAVE_W-1:0] FULL_POS = 16'sd16384;
    localparam logic signed [WAVE_W-1:0] FULL_NEG = -16'sd16384;
    localparam logic [63:0]              PI_Q30   = 64'd3373259426;

    typedef logic [14:0] t_qsine [0:64];

    // round(16384*sin(pi*k/128)) by an integer Taylor series, elaboration only
    function automatic logic [14:0] calc_qsine(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        rnd;
        x    = (PI_Q30 * 64'(k)) >> 7;
        term = x;
        acc  = signed'(x);
        for (int n = 1; n <= 10; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n[0]) begin
                acc = acc - signed'(term);
            end else begin
                acc = acc + signed'(term);
            end
        end
        if (acc < 0) begin
            acc = '0;
        end
        rnd = (unsigned'(acc) + 64'd32768) >> 16;
        return rnd[14:0];
    endfunction

    function automatic t_qsine build_qsine();
        t_qsine tab;
        for (int k = 0; k <= 64; k++) begin
            tab[k] = calc_qsine(k);
        end
        return tab;
    endfunction

    localparam t_qsine QSINE = build_qsine();

    function automatic logic signed [WAVE_W-1:0] full_sine(input logic [IDX_W-1:0] j);
        logic [6:0]               h;
        logic [6:0]               mirror;
        logic signed [WAVE_W-1:0] v;
        h      = j[6:0];
        mirror = 7'd0 - h;
        v      = (h <= 7'd64) ? signed'({1'b0, QSINE[h]}) : signed'({1'b0, QSINE[mirror]});
        return j[7] ? -v : v;
    endfunction

    logic signed [WAVE_W-1:0] sine_v;
    logic signed [WAVE_W-1:0] fast_v;
    logic signed [8:0]        tri_d;
    logic signed [WAVE_W-1:0] n_value;

    always_comb begin
        sine_v = full_sine(i_idx);
        fast_v = full_sine({i_idx[6:0], 1'b0});
        tri_d  = i_idx[7] ? (9'sd192 - signed'({1'b0, i_idx}))
                          : (signed'({1'b0, i_idx}) - 9'sd64);
        case (i_sel)
            WAVE_SINE:   n_value = sine_v;
            WAVE_HALF:   n_value = sine_v[WAVE_W-1] ? '0 : sine_v;
            WAVE_FAST:   n_value = i_idx[7] ? '0 : fast_v;
            WAVE_SQUARE: n_value = i_idx[7] ? FULL_NEG : FULL_POS;
            WAVE_TRI:    n_value = signed'({tri_d[7:0], 8'b0});
            WAVE_SAW:    n_value = signed'({~i_idx[7], ~i_idx[7], i_idx[6:0], 7'b0});
            default:     n_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_value <= n_value;
        end
    end

endmodule

@@ rtl/fmv_div.sv @@
`timescale 1ns / 1ps
// Phase increment unit: floor(x * 2^PHASE_BITS / DIVISOR) modulo 2^PHASE_BITS by
// reciprocal multiplication; o_done pulses as o_quot takes the result. Depends on fmv_pkg.
module fmv_div import fmv_pkg::*; #(
    parameter int PHASE_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [X_W-1:0]        i_x,
    output logic                  o_done,
    output logic [PHASE_BITS-1:0] o_quot
);

    // x * 2^P / DIVISOR = (x << SHIFT) / DIV_ODD; split x = hi * DIV_ODD + rem,
    // then the quotient is (hi << SHIFT) + (rem << SHIFT) / DIV_ODD
    localparam int SHIFT = PHASE_BITS - DIV_POW;
    localparam int QHI_W = X_W - DIV_ODD_W + 1;
    localparam int MUL_W = NUM_W + RECIP_W;
    localparam int QF_W  = MUL_W - RECIP_SHIFT;
    localparam logic [DIV_ODD_W-1:0] DIV_ODD_V = DIV_ODD_W'(DIV_ODD);

    logic [3:0]            r_stage;
    logic                  r_done;
    logic [X_W-1:0]        r_x;
    logic [NUM_W-1:0]      r_num;
    logic [QF_W-1:0]       r_q;
    logic [QHI_W-1:0]      r_qhi;
    logic [PHASE_BITS-1:0] r_quot;

    logic [MUL_W-1:0] mul_p;
    logic [X_W-1:0]   hi_times_odd;
    logic [X_W-1:0]   rem_wide;
    logic [NUM_W-1:0] rem_num;

    always_comb begin
        mul_p        = {{RECIP_W{1'b0}}, r_num} * {{NUM_W{1'b0}}, RECIP};
        hi_times_odd = {{(X_W-QHI_W){1'b0}}, r_q[QHI_W-1:0]}
                       * {{(X_W-DIV_ODD_W){1'b0}}, DIV_ODD_V};
        rem_wide     = r_x - hi_times_odd;
        rem_num      = {{(NUM_W-DIV_ODD_W){1'b0}}, rem_wide[DIV_ODD_W-1:0]} << SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= {r_stage[2:0], i_start};
            r_done  <= r_stage[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_num <= {{(NUM_W-X_W){1'b0}}, i_x};
        end else if (r_stage[1]) begin
            r_num <= rem_num;
        end
        if (r_stage[0] || r_stage[2]) begin
            r_q <= mul_p[RECIP_SHIFT +: QF_W];
        end
        if (r_stage[1]) begin
            r_qhi <= r_q[QHI_W-1:0];
        end
        // low part stays below 2^SHIFT, so the sum is a concatenation; drop the wrap
        if (r_stage[3]) begin
            r_quot <= {r_qhi[DIV_POW-1:0], r_q[SHIFT-1:0]};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ rtl/fmv_datapath.sv @@
`timescale 1ns / 1ps
// FM voice datapath: registers, phase accumulators and increments, shared
// multiplier, waveform ROM and sample scaling. Depends on fmv_pkg, fmv_div, fmv_wave_rom.
module fmv_datapath import fmv_pkg::*; #(
    parameter int PHASE_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    output t_dp_sts                     o_sts,
    output logic signed [SAMPLE_W-1:0]  o_sample
);

    logic [15:0] r_frequency;
    logic [7:0]  r_ratio_op2;
    logic [7:0]  r_ratio_op3;
    logic [7:0]  r_ratio_op4;
    logic [7:0]  r_carrier_level;
    logic [23:0] r_mod_levels;
    logic [15:0] r_wave_selects;

    logic [PHASE_BITS-1:0] r_phase [4];
    logic [PHASE_BITS-1:0] r_inc [4];

    logic signed [PROD_W-1:0]   r_prod;
    logic signed [SAMPLE_W-1:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frequency     <= '0;
            r_ratio_op2     <= '0;
            r_ratio_op3     <= '0;
            r_ratio_op4     <= '0;
            r_carrier_level <= '0;
            r_mod_levels    <= '0;
            r_wave_selects  <= '0;
        end else if (i_cmd.cfg_we) begin
            unique case (i_cfg_index)
                CFG_FREQUENCY:        r_frequency     <= i_cfg_data[15:0];
                CFG_RATIO_OP2:        r_ratio_op2     <= i_cfg_data[7:0];
                CFG_RATIO_OP3:        r_ratio_op3     <= i_cfg_data[7:0];
                CFG_RATIO_OP4:        r_ratio_op4     <= i_cfg_data[7:0];
                CFG_CARRIER_LEVEL:    r_carrier_level <= i_cfg_data[7:0];
                CFG_MODULATOR_LEVELS: r_mod_levels    <= i_cfg_data;
                CFG_WAVE_SELECTS:     r_wave_selects  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Divider operand: carrier uses 16*f, modulators f*ratio
    logic [7:0]     ratio_sel;
    logic [X_W-1:0] div_x;
    logic           div_done;
    logic [PHASE_BITS-1:0] div_quot;

    always_comb begin
        case (i_cmd.op)
            OP2:     ratio_sel = r_ratio_op2;
            OP3:     ratio_sel = r_ratio_op3;
            OP4:     ratio_sel = r_ratio_op4;
            default: ratio_sel = '0;
        endcase
        if (i_cmd.op == OP1) begin
            div_x = {4'b0, r_frequency, 4'b0};
        end else begin
            div_x = r_frequency * ratio_sel;
        end
    end

    fmv_div #(
        .PHASE_BITS (PHASE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_x     (div_x),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_sts.div_done = div_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_phase[k] <= '0;
                r_inc[k]   <= '0;
            end
        end else begin
            if (i_cmd.inc_store) begin
                r_inc[i_cmd.op] <= div_quot;
            end
            if (i_cmd.phase_adv) begin
                for (int k = 0; k < 4; k++) begin
                    r_phase[k] <= r_phase[k] + r_inc[k];
                end
            end
        end
    end

    // Shared multiplier: previous value times level, or carrier times level*127
    logic signed [WAVE_W-1:0] rom_q;
    logic signed [WAVE_W-1:0] mul_a;
    logic [14:0]              mul_b;
    logic [7:0]               level_sel;
    logic [14:0]              carrier_127;

    always_comb begin
        case (i_cmd.op)
            OP1:     level_sel = r_mod_levels[7:0];
            OP2:     level_sel = r_mod_levels[15:8];
            OP3:     level_sel = r_mod_levels[23:16];
            default: level_sel = '0;
        endcase
        carrier_127 = {r_carrier_level, 7'b0} - {7'b0, r_carrier_level};
        mul_a = (i_cmd.op == OP4 && !i_cmd.mul_scale) ? '0 : rom_q;
        mul_b = i_cmd.mul_scale ? carrier_127 : {7'b0, level_sel};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * signed'({1'b0, mul_b});
        end
    end

    // Table index: top bits of phase plus the modulation term
    logic [PHASE_BITS-1:0] phase_sel;
    logic [FRAC_W-1:0]     phase_frac;
    logic [FRAC_W-1:0]     idx_sum;
    logic [3:0]            wave_sel;

    assign phase_sel = r_phase[i_cmd.op];

    generate
        if (PHASE_BITS >= FRAC_W) begin : g_frac_trunc
            assign phase_frac = phase_sel[PHASE_BITS-1 -: FRAC_W];
        end else begin : g_frac_pad
            assign phase_frac = {phase_sel, {(FRAC_W - PHASE_BITS){1'b0}}};
        end
    endgenerate

    always_comb begin
        idx_sum = phase_frac + r_prod[FRAC_W-1:0];
        case (i_cmd.op)
            OP1:     wave_sel = r_wave_selects[15:12];
            OP2:     wave_sel = r_wave_selects[11:8];
            OP3:     wave_sel = r_wave_selects[7:4];
            default: wave_sel = r_wave_selects[3:0];
        endcase
    end

    fmv_wave_rom u_rom (
        .i_clk   (i_clk),
        .i_en    (i_cmd.look_en),
        .i_sel   (wave_sel),
        .i_idx   (idx_sum[FRAC_W-1 -: IDX_W]),
        .o_value (rom_q)
    );

    // Divide by 2^14 rounding toward zero
    logic signed [PROD_W-1:0] prod_adj;

    assign prod_adj = r_prod + (r_prod[PROD_W-1] ? 32'sd16383 : 32'sd0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_sample <= prod_adj[14 +: SAMPLE_W];
        end
    end

    assign o_sample = r_sample;

endmodule

@@ rtl/fmv_ctrl.sv @@
`timescale 1ns / 1ps
// FM voice controller: sequences increment updates and the operator chain,
// owns the channel handshakes. Depends on fmv_pkg.
module fmv_ctrl import fmv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tick_valid,
    input  logic                 i_tick,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_out_ready,
    input  t_dp_sts              i_sts,
    output logic                 o_tick_ready,
    output logic                 o_cfg_ready,
    output logic                 o_out_valid,
    output t_dp_cmd              o_cmd
);

    t_fmv_state r_state;
    t_fmv_state n_state;
    logic [1:0] r_op;
    logic [1:0] n_op;
    logic       r_out_valid;
    logic       n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        o_cmd        = '0;
        o_cmd.op     = r_op;
        o_tick_ready = 1'b0;
        o_cfg_ready  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_cfg_ready  = 1'b1;
                o_tick_ready = !i_cfg_valid;
                if (i_cfg_valid) begin
                    o_cmd.cfg_we = 1'b1;
                    // frequency or a ratio changed: recompute all increments
                    if (i_cfg_index <= CFG_RATIO_OP4) begin
                        n_op    = OP1;
                        n_state = S_DIV_START;
                    end
                end else if (i_tick_valid && i_tick) begin
                    n_state = S_ADVANCE;
                end
            end
            S_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.inc_store = 1'b1;
                    if (r_op == OP4) begin
                        n_state = S_IDLE;
                    end else begin
                        n_op    = r_op + 2'd1;
                        n_state = S_DIV_START;
                    end
                end
            end
            S_ADVANCE: begin
                o_cmd.phase_adv = 1'b1;
                n_op            = OP4;
                n_state         = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_LOOK;
            end
            S_LOOK: begin
                o_cmd.look_en = 1'b1;
                if (r_op == OP1) begin
                    n_state = S_SCALE;
                end else begin
                    n_op    = r_op - 2'd1;
                    n_state = S_MUL;
                end
            end
            S_SCALE: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_scale = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                // hold the finished sample until the output slot frees
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/four_operator_fm_voice_core.sv @@
`timescale 1ns / 1ps
// Four-operator serial FM voice (4 -> 3 -> 2 -> 1), top level.
// Depends on fmv_pkg, fmv_if, fmv_ctrl, fmv_datapath.
//
// Channels: i_tick_ch takes one request per sample period; a request with
// tick low is taken and dropped. o_sample_ch returns one signed 16-bit
// sample per tick. i_cfg_ch writes the voice registers by index:
// 0 frequency, 1..3 ratios of operators 2..4, 4 carrier level,
// 5 modulator levels, 6 wave selects; other indexes are ignored.
// After a tick is taken, the steps are the phase update, a multiply on the
// shared multiplier and a registered waveform ROM lookup per operator, the
// carrier scaling and the load of the output register; the next tick is
// taken only once that load is done and the controller is idle again.
// A write to the frequency or a ratio recomputes the four phase increments
// by reciprocal multiplication, one after another, with both input
// channels held not ready meanwhile.
// Reset clears the voice registers, phases and increments; no clearing pass.
// When the receiver stalls, the finished sample waits in the output
// register; the next tick is still taken and its work runs up to the
// output step, where it holds until the slot frees.
module four_operator_fm_voice_core import fmv_pkg::*; #(
    parameter int PHASE_BITS = 24
) (
    input logic            i_clk,
    input logic            i_rst_n,
    fmv_tick_if.sink       i_tick_ch,
    fmv_sample_if.source   o_sample_ch,
    fmv_cfg_if.sink        i_cfg_ch
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    fmv_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_valid (i_tick_ch.valid),
        .i_tick       (i_tick_ch.tick),
        .i_cfg_valid  (i_cfg_ch.valid),
        .i_cfg_index  (i_cfg_ch.index),
        .i_out_ready  (o_sample_ch.ready),
        .i_sts        (dp_sts),
        .o_tick_ready (i_tick_ch.ready),
        .o_cfg_ready  (i_cfg_ch.ready),
        .o_out_valid  (o_sample_ch.valid),
        .o_cmd        (dp_cmd)
    );

    fmv_datapath #(
        .PHASE_BITS (PHASE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_cfg_index (i_cfg_ch.index),
        .i_cfg_data  (i_cfg_ch.data),
        .o_sts       (dp_sts),
        .o_sample    (o_sample_ch.sample)
    );

endmodule
